>>> src/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared widths, register indexes, reset values and types for the layer
// LED breathing controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// Field widths
	localparam int LEVEL_W = 7;
	localparam int IVL_W   = 16;
	localparam int LAYER_W = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATIC_LEVEL    = 3'd0,
		REG_RAMP_MIN        = 3'd1,
		REG_RAMP_MAX        = 3'd2,
		REG_RAMP_STEP       = 3'd3,
		REG_INTERVAL_LOWER  = 3'd4,
		REG_INTERVAL_UPPER  = 3'd5,
		REG_INTERVAL_ADJUST = 3'd6,
		REG_START_DELAY     = 3'd7
	} cfg_reg_t;

	// Item kinds
	localparam logic FUNC_POLL = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Register reset values
	localparam logic [LEVEL_W-1:0] RST_STATIC_LEVEL    = 7'd80;
	localparam logic [LEVEL_W-1:0] RST_RAMP_MIN        = 7'd10;
	localparam logic [LEVEL_W-1:0] RST_RAMP_MAX        = 7'd100;
	localparam logic [LEVEL_W-1:0] RST_RAMP_STEP       = 7'd5;
	localparam logic [IVL_W-1:0]   RST_INTERVAL_LOWER  = 16'd28;
	localparam logic [IVL_W-1:0]   RST_INTERVAL_UPPER  = 16'd14;
	localparam logic [IVL_W-1:0]   RST_INTERVAL_ADJUST = 16'd7;
	localparam logic [IVL_W-1:0]   RST_START_DELAY     = 16'd100;

	// Breathe ramp position
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               rising;
	} ramp_t;

	// Ramp limits handed to the ramp stepper
	typedef struct packed {
		logic [LEVEL_W-1:0] lo;
		logic [LEVEL_W-1:0] hi;
		logic [LEVEL_W-1:0] step;
	} ramp_cfg_t;

endpackage

>>> src/lbc_ramp.sv
// ----------------------------------------------------------------------------
// lbc_ramp
// One breathe step: moves the ramp level by the step size and turns the
// direction at the upper and lower limits.
// ----------------------------------------------------------------------------
module lbc_ramp (
	input  lbc_pkg::ramp_t     cur,
	input  lbc_pkg::ramp_cfg_t cfg,
	output lbc_pkg::ramp_t     nxt
);
	import lbc_pkg::*;

	logic [LEVEL_W:0] up_sum;
	logic [LEVEL_W:0] down_floor;

	assign up_sum     = {1'b0, cur.level} + {1'b0, cfg.step};
	assign down_floor = {1'b0, cfg.lo} + {1'b0, cfg.step};

	// Rising: clamp to max and turn; falling: clamp to min and turn
	always_comb begin
		nxt = cur;
		if (cur.rising) begin
			if (up_sum >= {1'b0, cfg.hi}) begin
				nxt.level  = cfg.hi;
				nxt.rising = 1'b0;
			end else begin
				nxt.level = up_sum[LEVEL_W-1:0];
			end
		end else begin
			if ({1'b0, cur.level} <= down_floor) begin
				nxt.level  = cfg.lo;
				nxt.rising = 1'b1;
			end else begin
				nxt.level = cur.level - cfg.step;
			end
		end
	end

endmodule

>>> src/layer_led_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// layer_led_breathing_controller_unit
// Drives one backlight level from layer/activity poll samples and
// millisecond ticks: static level on layer 0, a breathe ramp on layers 1-3,
// off when idle or on any other layer.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_ready              sink       func, layer, active
//   out      out_valid / out_ready            source     brightness, write_strobe
//   cfg      cfg_valid / cfg_ready            sink       cfg_index, cfg_data
//
// One item per clock sustained while out_ready holds. An item waits in the
// input register and is resolved into the result register once that frees.
// The result register stalls on out_ready; the input register keeps
// accepting while it is free or moving on. Reset clears all control state
// and loads the register defaults; no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module layer_led_breathing_controller_unit #(
	parameter int LAYER_BITS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [lbc_pkg::LAYER_W-1:0]       layer,
	input  logic                              active,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lbc_pkg::LEVEL_W-1:0]       brightness,
	output logic                              write_strobe,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lbc_pkg::*;

	localparam int LB_USED = (LAYER_BITS < LAYER_W) ? LAYER_BITS : LAYER_W;

	// Configuration registers
	logic [LEVEL_W-1:0] static_level_q, ramp_min_q, ramp_max_q, ramp_step_q;
	logic [IVL_W-1:0]   ivl_lower_q, ivl_upper_q, ivl_adjust_q, start_delay_q;

	// Input register
	logic                  valid_s1;
	logic                  func_s1;
	logic [LAYER_BITS-1:0] layer_s1;
	logic                  active_s1;

	// Block state
	logic                  layer_known_q;
	logic [LAYER_BITS-1:0] stored_layer_q;
	logic                  stored_active_q;
	ramp_t                 ramp_q;
	logic                  step_armed_q;
	logic [IVL_W-1:0]      countdown_q;
	logic [LEVEL_W-1:0]    drive_q;

	// Result register
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    bright_q;
	logic                  strobe_q;

	// Next-state values
	logic                  advance, process;
	logic                  known_d, stored_active_d, armed_d, strobe_d;
	logic [LAYER_BITS-1:0] stored_layer_d;
	ramp_t                 ramp_d, ramp_step_nxt;
	ramp_cfg_t             ramp_cfg;
	logic [IVL_W-1:0]      countdown_d, stored_ivl;
	logic [LEVEL_W-1:0]    drive_d;
	logic                  changed, new_breathes, old_breathes;

	assign cfg_ready = 1'b1;

	// Handshake: result register frees when empty or taken
	assign advance  = !out_valid_q || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign out_valid    = out_valid_q;
	assign brightness   = bright_q;
	assign write_strobe = strobe_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_level_q <= RST_STATIC_LEVEL;
			ramp_min_q     <= RST_RAMP_MIN;
			ramp_max_q     <= RST_RAMP_MAX;
			ramp_step_q    <= RST_RAMP_STEP;
			ivl_lower_q    <= RST_INTERVAL_LOWER;
			ivl_upper_q    <= RST_INTERVAL_UPPER;
			ivl_adjust_q   <= RST_INTERVAL_ADJUST;
			start_delay_q  <= RST_START_DELAY;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_STATIC_LEVEL:    static_level_q <= cfg_data[LEVEL_W-1:0];
				REG_RAMP_MIN:        ramp_min_q     <= cfg_data[LEVEL_W-1:0];
				REG_RAMP_MAX:        ramp_max_q     <= cfg_data[LEVEL_W-1:0];
				REG_RAMP_STEP:       ramp_step_q    <= cfg_data[LEVEL_W-1:0];
				REG_INTERVAL_LOWER:  ivl_lower_q    <= cfg_data;
				REG_INTERVAL_UPPER:  ivl_upper_q    <= cfg_data;
				REG_INTERVAL_ADJUST: ivl_adjust_q   <= cfg_data;
				REG_START_DELAY:     start_delay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1   <= func;
			layer_s1  <= LAYER_BITS'(layer[LB_USED-1:0]);
			active_s1 <= active;
		end
	end

	// Ramp stepper
	assign ramp_cfg = '{lo: ramp_min_q, hi: ramp_max_q, step: ramp_step_q};

	lbc_ramp u_ramp (
		.cur (ramp_q),
		.cfg (ramp_cfg),
		.nxt (ramp_step_nxt)
	);

	// Interval of the stored layer
	always_comb begin
		case (stored_layer_q)
			LAYER_BITS'(1): stored_ivl = ivl_lower_q;
			LAYER_BITS'(2): stored_ivl = ivl_upper_q;
			LAYER_BITS'(3): stored_ivl = ivl_adjust_q;
			default:        stored_ivl = '0;
		endcase
	end

	assign changed      = !layer_known_q || (layer_s1 != stored_layer_q) ||
	                      (active_s1 != stored_active_q);
	assign new_breathes = (layer_s1 != '0) && (layer_s1 <= LAYER_BITS'(3));
	assign old_breathes = stored_active_q && (stored_layer_q != '0) &&
	                      (stored_layer_q <= LAYER_BITS'(3));

	// Item resolution
	always_comb begin
		known_d         = layer_known_q;
		stored_layer_d  = stored_layer_q;
		stored_active_d = stored_active_q;
		ramp_d          = ramp_q;
		armed_d         = step_armed_q;
		countdown_d     = countdown_q;
		drive_d         = drive_q;
		strobe_d        = 1'b0;
		if (func_s1 == FUNC_POLL) begin
			if (changed) begin
				known_d         = 1'b1;
				stored_layer_d  = layer_s1;
				stored_active_d = active_s1;
				armed_d         = 1'b0;
				countdown_d     = '0;
				ramp_d.level    = ramp_min_q;
				ramp_d.rising   = 1'b1;
				if (!active_s1) begin
					drive_d  = '0;
					strobe_d = 1'b1;
				end else if (layer_s1 == '0) begin
					drive_d  = static_level_q;
					strobe_d = 1'b1;
				end else if (new_breathes) begin
					armed_d     = 1'b1;
					countdown_d = start_delay_q;
				end else begin
					drive_d  = '0;
					strobe_d = 1'b1;
				end
			end
		end else if (step_armed_q) begin
			if (countdown_q > IVL_W'(1)) begin
				countdown_d = countdown_q - IVL_W'(1);
			end else begin
				strobe_d = 1'b1;
				if (!old_breathes) begin
					drive_d     = '0;
					armed_d     = 1'b0;
					countdown_d = '0;
				end else begin
					drive_d     = ramp_q.level;
					ramp_d      = ramp_step_nxt;
					countdown_d = stored_ivl;
				end
			end
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_known_q   <= 1'b0;
			stored_layer_q  <= '0;
			stored_active_q <= 1'b0;
			ramp_q          <= '{level: RST_RAMP_MIN, rising: 1'b1};
			step_armed_q    <= 1'b0;
			countdown_q     <= '0;
			drive_q         <= '0;
		end else if (process) begin
			layer_known_q   <= known_d;
			stored_layer_q  <= stored_layer_d;
			stored_active_q <= stored_active_d;
			ramp_q          <= ramp_d;
			step_armed_q    <= armed_d;
			countdown_q     <= countdown_d;
			drive_q         <= drive_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			bright_q <= drive_d;
			strobe_q <= strobe_d;
		end
	end

endmodule

>>> src/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks for the layer LED breathing controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module lbc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [lbc_pkg::LEVEL_W-1:0]    brightness,
	input logic                           write_strobe,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);
	import lbc_pkg::*;

	logic               seen_q;
	logic [LEVEL_W-1:0] last_q;

	// Last delivered level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q <= 1'b1;
			last_q <= brightness;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(brightness) &&
		$stable(write_strobe))
		else $error("result changed while stalled");

	// Level only moves on a strobe
	a_level_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !write_strobe && seen_q |-> brightness == last_q)
		else $error("level changed without a write");

	// LEDs start dark
	a_level_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !write_strobe && !seen_q |-> brightness == '0)
		else $error("nonzero level without a write after reset");

	// A new result follows an item accepted through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted item");

	// Configuration never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind layer_led_breathing_controller_unit lbc_checker u_lbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.brightness   (brightness),
	.write_strobe (write_strobe),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

>>> tb/sv/tb_layer_led_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_layer_led_breathing_controller_unit
// Self-checking bench for the layer LED breathing controller. A queue-fed
// driver offers poll samples and millisecond ticks with random gaps, a
// monitor takes results with random stalls and checks each one against a
// behavioral prediction of level and write strobe. Register settings are
// changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_layer_led_breathing_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lbc_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 12;
	localparam int LONG_STALL     = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	// Idle pattern for one side of the block
	typedef enum int {
		PACE_NONE,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	typedef struct packed {
		logic               func;
		logic [LAYER_W-1:0] layer;
		logic               active;
	} led_cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               strobe;
	} led_out_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  func         = FUNC_POLL;
	logic [LAYER_W-1:0]    layer        = '0;
	logic                  active       = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [LEVEL_W-1:0]    brightness;
	logic                  write_strobe;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	led_cmd_t pending_cmds[$];
	led_out_t expected_levels[$];
	pace_t    src_pace = PACE_NONE;
	pace_t    sink_pace = PACE_NONE;
	int       src_wait = 0;
	int       sink_wait = 0;
	int       results_seen = 0;
	int       idle_cycles = 0;
	int       mismatches = 0;

	// Register mirror
	logic [LEVEL_W-1:0] cf_static = RST_STATIC_LEVEL;
	logic [LEVEL_W-1:0] cf_min    = RST_RAMP_MIN;
	logic [LEVEL_W-1:0] cf_max    = RST_RAMP_MAX;
	logic [LEVEL_W-1:0] cf_step   = RST_RAMP_STEP;
	logic [IVL_W-1:0]   cf_lower  = RST_INTERVAL_LOWER;
	logic [IVL_W-1:0]   cf_upper  = RST_INTERVAL_UPPER;
	logic [IVL_W-1:0]   cf_adjust = RST_INTERVAL_ADJUST;
	logic [IVL_W-1:0]   cf_delay  = RST_START_DELAY;

	// Predicted controller state
	logic               layer_seen  = 1'b0;
	logic [LAYER_W-1:0] held_layer  = '0;
	logic               held_active = 1'b0;
	logic [LEVEL_W-1:0] ramp_lvl    = RST_RAMP_MIN;
	logic               ramp_up     = 1'b1;
	logic               armed       = 1'b0;
	logic [IVL_W-1:0]   step_count  = '0;
	logic [LEVEL_W-1:0] led_level   = '0;

	layer_led_breathing_controller_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.layer        (layer),
		.active       (active),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.brightness   (brightness),
		.write_strobe (write_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_gap(pace_t p);
		case (p)
			PACE_NONE:  return 0;
			PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			default:    return $urandom_range(0, 16);
		endcase
	endfunction

	// Step interval of a breathing layer, zero for any other layer
	function automatic logic [IVL_W-1:0] interval_of(logic [LAYER_W-1:0] lay);
		case (lay)
			1:       return cf_lower;
			2:       return cf_upper;
			3:       return cf_adjust;
			default: return '0;
		endcase
	endfunction

	// Level and strobe produced by one item; updates the predicted state
	function automatic led_out_t predict_led(logic kind, logic [LAYER_W-1:0] lay, logic act);
		led_out_t res;
		logic     strobe;
		strobe = 1'b0;
		if (kind == FUNC_POLL) begin
			if (!layer_seen || lay != held_layer || act != held_active) begin
				layer_seen  = 1'b1;
				held_layer  = lay;
				held_active = act;
				armed       = 1'b0;
				step_count  = '0;
				ramp_lvl    = cf_min;
				ramp_up     = 1'b1;
				if (!act) begin
					led_level = '0;
					strobe    = 1'b1;
				end else if (lay == 0) begin
					led_level = cf_static;
					strobe    = 1'b1;
				end else if (lay <= 3) begin
					// LEDs keep their level until the first breathe step
					armed      = 1'b1;
					step_count = cf_delay;
				end else begin
					led_level = '0;
					strobe    = 1'b1;
				end
			end
		end else if (armed) begin
			if (step_count > 1) begin
				step_count = step_count - IVL_W'(1);
			end else begin
				strobe = 1'b1;
				if (!(held_active && held_layer >= 1 && held_layer <= 3)) begin
					led_level  = '0;
					armed      = 1'b0;
					step_count = '0;
				end else begin
					led_level = ramp_lvl;
					// move the ramp, turning at the limits
					if (ramp_up) begin
						if (int'(ramp_lvl) + int'(cf_step) >= int'(cf_max)) begin
							ramp_lvl = cf_max;
							ramp_up  = 1'b0;
						end else begin
							ramp_lvl = ramp_lvl + cf_step;
						end
					end else if (int'(ramp_lvl) <= int'(cf_min) + int'(cf_step)) begin
						ramp_lvl = cf_min;
						ramp_up  = 1'b1;
					end else begin
						ramp_lvl = ramp_lvl - cf_step;
					end
					step_count = interval_of(held_layer);
				end
			end
		end
		res.level  = led_level;
		res.strobe = strobe;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Driver: launches queued items, predicts each one on acceptance
	always @(posedge clk or negedge arst_n) begin : source
		led_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_wait <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_levels.push_back(predict_led(func, layer, active));
			if (!in_valid || in_ready) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					nxt = pending_cmds.pop_front();
					func     <= nxt.func;
					layer    <= nxt.layer;
					active   <= nxt.active;
					in_valid <= 1'b1;
					src_wait <= draw_gap(src_pace);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks results, stalls at random, holds off twice for long
	always @(posedge clk or negedge arst_n) begin : sink
		int       gap;
		led_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else begin
			gap = sink_wait;
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("result with nothing expected", int'(brightness), -1);
				end else begin
					want = expected_levels.pop_front();
					if (brightness !== want.level)
						report_mismatch("brightness", int'(brightness), int'(want.level));
					if (write_strobe !== want.strobe)
						report_mismatch("write_strobe", int'(write_strobe),
						                int'(want.strobe));
				end
				results_seen <= results_seen + 1;
				gap = draw_gap(sink_pace);
				if (results_seen == 150 || results_seen == 520)
					gap = LONG_STALL;
			end else if (gap > 0) begin
				gap--;
			end
			sink_wait <= gap;
			out_ready <= (gap == 0);
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_item(logic kind, logic [LAYER_W-1:0] lay, logic act);
		led_cmd_t c;
		c.func   = kind;
		c.layer  = lay;
		c.active = act;
		pending_cmds.push_back(c);
	endtask

	task automatic add_ticks(int n);
		repeat (n) add_item(FUNC_TICK, LAYER_W'($urandom_range(0, 31)),
		                    1'($urandom_range(0, 1)));
	endtask

	// Wait until every queued item went through and every result arrived
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STATIC_LEVEL:    cf_static = val[LEVEL_W-1:0];
			REG_RAMP_MIN:        cf_min    = val[LEVEL_W-1:0];
			REG_RAMP_MAX:        cf_max    = val[LEVEL_W-1:0];
			REG_RAMP_STEP:       cf_step   = val[LEVEL_W-1:0];
			REG_INTERVAL_LOWER:  cf_lower  = val;
			REG_INTERVAL_UPPER:  cf_upper  = val;
			REG_INTERVAL_ADJUST: cf_adjust = val;
			REG_START_DELAY:     cf_delay  = val;
			default: ;
		endcase
	endtask

	// Drain the block, then rewrite every register
	task automatic load_settings(int sl, int lo, int hi, int stp, int il, int iu, int ia,
	                             int dly);
		drain();
		write_reg(REG_STATIC_LEVEL, CFG_DATA_W'(sl));
		write_reg(REG_RAMP_MIN, CFG_DATA_W'(lo));
		write_reg(REG_RAMP_MAX, CFG_DATA_W'(hi));
		write_reg(REG_RAMP_STEP, CFG_DATA_W'(stp));
		write_reg(REG_INTERVAL_LOWER, CFG_DATA_W'(il));
		write_reg(REG_INTERVAL_UPPER, CFG_DATA_W'(iu));
		write_reg(REG_INTERVAL_ADJUST, CFG_DATA_W'(ia));
		write_reg(REG_START_DELAY, CFG_DATA_W'(dly));
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_interval();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
	endfunction

	// Random segments: mostly a breathing layer followed by a run of ticks
	// long enough to reach several steps, the rest static, idle and noise
	task automatic add_random(int want);
		int                 base;
		int                 live;
		int                 r;
		int                 run;
		int                 lim;
		logic [LAYER_W-1:0] lay;
		logic               act;
		base = pending_cmds.size();
		live = 0;
		while (live < want) begin
			r   = $urandom_range(0, 99);
			act = 1'b1;
			if (r < 55) begin
				lay = LAYER_W'($urandom_range(1, 3));
			end else if (r < 65) begin
				lay = 0;
			end else if (r < 80) begin
				lay = LAYER_W'($urandom_range(4, 31));
			end else begin
				lay = LAYER_W'($urandom_range(0, 31));
				act = 1'($urandom_range(0, 1));
			end
			add_item(FUNC_POLL, lay, act);
			if (act && lay >= 1 && lay <= 3) begin
				lim = int'(cf_delay) + 4 * int'(interval_of(lay)) + 4;
				if (lim > 160)
					lim = 160;
				run = $urandom_range(1, lim);
			end else begin
				run = $urandom_range(0, 3);
			end
			// keep the phase near its item budget
			live = pending_cmds.size() - base;
			if (run > want - live)
				run = want - live;
			repeat (run) begin
				r = $urandom_range(0, 59);
				if (r < 5)
					add_item(FUNC_POLL, lay, act);
				else if (r == 5)
					add_item(FUNC_POLL, LAYER_W'($urandom_range(0, 31)),
					         1'($urandom_range(0, 1)));
				add_ticks(1);
			end
			live = pending_cmds.size() - base;
		end
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: unarmed tick, first poll, static, idle, other layers
		src_pace  = PACE_LIGHT;
		sink_pace = PACE_LIGHT;
		add_ticks(1);
		add_item(FUNC_POLL, 0, 1'b0);
		add_item(FUNC_POLL, 0, 1'b0);
		add_item(FUNC_POLL, 0, 1'b1);
		add_item(FUNC_POLL, 1, 1'b1);
		add_item(FUNC_POLL, 31, 1'b1);
		add_item(FUNC_POLL, 4, 1'b1);
		add_item(FUNC_POLL, 3, 1'b0);
		add_item(FUNC_POLL, 2, 1'b1);
		add_item(FUNC_POLL, 2, 1'b1);
		add_ticks(1);
		add_random(180);

		// Zero delay and lower interval, small ramp with both turns
		load_settings(0, 0, 7, 3, 0, 1, 2, 0);
		src_pace  = PACE_NONE;
		sink_pace = PACE_NONE;
		add_item(FUNC_POLL, 1, 1'b1);
		add_ticks(8);
		add_item(FUNC_POLL, 2, 1'b1);
		add_ticks(4);
		add_item(FUNC_POLL, 3, 1'b1);
		add_ticks(5);
		add_item(FUNC_POLL, 0, 1'b1);
		add_random(100);

		// Level registers at 100, intervals at their maximum, start delay of one
		load_settings(100, 100, 100, 100, 65535, 65535, 65535, 1);
		src_pace  = PACE_HEAVY;
		sink_pace = PACE_NONE;
		add_item(FUNC_POLL, 2, 1'b1);
		add_ticks(3);
		add_item(FUNC_POLL, 0, 1'b1);
		add_item(FUNC_POLL, 0, 1'b0);
		add_random(80);

		// Maximum below minimum, maximum at zero
		load_settings(37, 90, 0, 7, 3, 2, 1, 2);
		src_pace  = PACE_NONE;
		sink_pace = PACE_HEAVY;
		add_item(FUNC_POLL, 3, 1'b1);
		add_ticks(6);
		add_random(100);

		// Random settings
		for (int ph = 0; ph < 4; ph++) begin
			load_settings($urandom_range(0, 100), $urandom_range(0, 100),
			              $urandom_range(0, 100),
			              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100)
			                                          : $urandom_range(1, 12),
			              pick_interval(), pick_interval(), pick_interval(),
			              $urandom_range(0, 12));
			src_pace  = pace_t'($urandom_range(0, 2));
			sink_pace = pace_t'($urandom_range(0, 2));
			add_random(90);
		end

		drain();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
src/lbc_pkg.sv
src/lbc_ramp.sv
src/layer_led_breathing_controller_unit.sv
src/lbc_checker.sv
tb/sv/tb_layer_led_breathing_controller_unit.sv
